[src/sfd_pkg.sv]
`timescale 1ns / 1ps
package sfd_pkg;

    localparam int MAX_FRAME_BYTES = 30;
    localparam int MAX_SENSORS     = 14;

    localparam int BYTE_W   = 8;
    localparam int CFG_W    = 4;
    localparam int FIELD_W  = 6;
    localparam int VALUE_W  = 2 * FIELD_W;
    localparam int IDX_W    = 4;
    localparam int CNT_W    = $clog2(MAX_FRAME_BYTES + 1);
    localparam int WORD_DEPTH = MAX_FRAME_BYTES / 2;
    localparam int ADDR_W   = (WORD_DEPTH > 1) ? $clog2(WORD_DEPTH) : 1;

    localparam logic [BYTE_W-1:0] NEWLINE     = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_OFFSET = 8'h20;
    localparam logic [CFG_W-1:0]  SENSOR_COUNT_RESET = 4'd1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_CKSUM = 2'd1,
        ST_LEN   = 2'd2,
        ST_OVF   = 2'd3
    } t_frame_status;

    typedef struct packed {
        logic          store;
        logic          clear;
        logic          rd_first;
        logic          rd_next;
        logic          ld_err;
        t_frame_status err_code;
        logic          ld_val;
    } t_dp_cmd;

    typedef struct packed {
        logic newline;
        logic full;
        logic len_bad;
        logic sum_bad;
        logic rd_last;
        logic out_free;
    } t_dp_sts;

endpackage

[src/sfd_if.sv]
`timescale 1ns / 1ps
interface sfd_in_if;
    import sfd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_out_if;
    import sfd_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         frame_status;
    logic [IDX_W-1:0]   sensor_index;
    logic [VALUE_W-1:0] sensor_value;
    logic               last;

    modport source (output valid, output frame_status, output sensor_index,
                    output sensor_value, output last, input ready);
    modport sink   (input valid, input frame_status, input sensor_index,
                    input sensor_value, input last, output ready);
endinterface

[src/sensor_frame_deframer_top.sv]
`timescale 1ns / 1ps
// Sensor frame deframer.
// i_in carries one received serial byte per beat (valid/ready). Bytes other
// than newline are offset by 0x20 and stored; a newline closes the frame.
// o_out carries one result per beat: status, sensor index, 12-bit value and
// a last flag on the final result of a frame end.
// i_cfg_we / i_cfg_wdata write the sensor count; write it only while idle.
// A frame end with an error puts its single result on o_out in the cycle
// after the newline beat. A good frame gives its values one after another
// once the newline is taken: each value is one read of the 15-word frame
// memory, then a load of the output register, which waits while o_out is
// stalled. The next byte is taken once the last result of a frame is
// loaded and the output register is free or draining.
// While o_out is stalled the block holds its result and takes no byte.
// Reset (synchronous, active low) empties the frame, clears the discard
// flag and the output valid flag and sets the sensor count to 1; the frame
// memory keeps its contents.
module sensor_frame_deframer_top
    import sfd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    sfd_in_if.sink           i_in,
    sfd_out_if.source        o_out
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    sfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sfd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx_byte   (i_in.rx_byte),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out       (o_out)
    );

endmodule

[src/sfd_ctrl.sv]
`timescale 1ns / 1ps
module sfd_ctrl
    import sfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_LOAD = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_disc, n_disc;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE) && i_sts.out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_disc  = r_disc;
        o_cmd   = '{err_code: ST_OK, default: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    priority if (r_disc) begin
                        if (i_sts.newline) begin
                            n_disc      = 1'b0;
                            o_cmd.clear = 1'b1;
                        end
                    end else if (i_sts.newline) begin
                        o_cmd.clear = 1'b1;
                        priority if (i_sts.len_bad) begin
                            o_cmd.ld_err   = 1'b1;
                            o_cmd.err_code = ST_LEN;
                        end else if (i_sts.sum_bad) begin
                            o_cmd.ld_err   = 1'b1;
                            o_cmd.err_code = ST_CKSUM;
                        end else begin
                            o_cmd.rd_first = 1'b1;
                            n_state        = S_READ;
                        end
                    end else if (i_sts.full) begin
                        o_cmd.clear    = 1'b1;
                        o_cmd.ld_err   = 1'b1;
                        o_cmd.err_code = ST_OVF;
                        n_disc         = 1'b1;
                    end else begin
                        o_cmd.store = 1'b1;
                    end
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.ld_val = 1'b1;
                    if (i_sts.rd_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                        n_state       = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_disc  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_disc  <= n_disc;
        end
    end

endmodule

[src/sfd_dp.sv]
`timescale 1ns / 1ps
module sfd_dp
    import sfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    sfd_out_if.source         o_out
);

    logic [CFG_W-1:0]   r_sensor_count;
    logic [CNT_W-1:0]   r_count;
    logic [BYTE_W-1:0]  r_xor;
    logic [FIELD_W-1:0] r_hi;
    logic [VALUE_W-1:0] r_mem [WORD_DEPTH];
    logic [VALUE_W-1:0] r_rd_data;
    logic [IDX_W-1:0]   r_rd_idx;

    logic               r_out_valid;
    t_frame_status      r_out_status;
    logic [IDX_W-1:0]   r_out_index;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_last;

    logic [BYTE_W-1:0]  w_ch;
    logic [CNT_W-1:0]   w_frame_len;

    assign w_ch        = i_rx_byte - CHAR_OFFSET;
    assign w_frame_len = CNT_W'({r_sensor_count, 1'b1});

    assign o_sts.newline  = (i_rx_byte == NEWLINE);
    assign o_sts.full     = (r_count >= CNT_W'(MAX_FRAME_BYTES));
    assign o_sts.len_bad  = (r_sensor_count == '0)
                         || (r_sensor_count > CFG_W'(MAX_SENSORS))
                         || (r_count != w_frame_len);
    assign o_sts.sum_bad  = (r_xor != '0);
    assign o_sts.rd_last  = (CFG_W'(r_rd_idx + 1'b1) == r_sensor_count);
    assign o_sts.out_free = !r_out_valid || o_out.ready;

    // config and frame bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_count <= SENSOR_COUNT_RESET;
            r_count        <= '0;
            r_xor          <= '0;
        end else begin
            if (i_cfg_we) begin
                r_sensor_count <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_xor   <= '0;
            end else if (i_cmd.store) begin
                r_count <= r_count + 1'b1;
                r_xor   <= r_xor ^ w_ch;
            end
        end
    end

    // pack byte pairs into 12-bit words
    always_ff @(posedge i_clk) begin
        if (i_cmd.store && !r_count[0]) begin
            r_hi <= w_ch[FIELD_W-1:0];
        end
        if (i_cmd.store && r_count[0]) begin
            r_mem[ADDR_W'(r_count >> 1)] <= {r_hi, w_ch[FIELD_W-1:0]};
        end
        r_rd_data <= r_mem[ADDR_W'(r_rd_idx)];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_first) begin
            r_rd_idx <= '0;
        end else if (i_cmd.rd_next) begin
            r_rd_idx <= r_rd_idx + 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ld_err || i_cmd.ld_val) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_err) begin
            r_out_status <= i_cmd.err_code;
            r_out_index  <= '0;
            r_out_value  <= '0;
            r_out_last   <= 1'b1;
        end else if (i_cmd.ld_val) begin
            r_out_status <= ST_OK;
            r_out_index  <= r_rd_idx;
            r_out_value  <= r_rd_data;
            r_out_last   <= o_sts.rd_last;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.frame_status = r_out_status;
    assign o_out.sensor_index = r_out_index;
    assign o_out.sensor_value = r_out_value;
    assign o_out.last         = r_out_last;

endmodule

[src/sfd_chk.sv]
`timescale 1ns / 1ps
module sfd_chk
    import sfd_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [1:0]         i_status,
    input logic [IDX_W-1:0]   i_index,
    input logic [VALUE_W-1:0] i_value,
    input logic               i_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_value)
            && $stable(i_status) && $stable(i_last))
        else $error("result beat dropped or changed while stalled");

    a_no_take_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("byte taken while result is stalled");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_OK) |-> i_last && (i_index == '0)
            && (i_value == '0))
        else $error("error result malformed");

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result present after reset");

    a_no_take_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last |-> !(i_in_valid && i_in_ready))
        else $error("byte taken before frame results are done");

endmodule

bind sensor_frame_deframer_top sfd_chk u_sfd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.frame_status),
    .i_index     (o_out.sensor_index),
    .i_value     (o_out.sensor_value),
    .i_last      (o_out.last)
);

[tb/sv/tb_sensor_frame_deframer_top.sv]
`timescale 1ns / 1ps
module tb_sensor_frame_deframer_top;
    import sfd_pkg::*;

    typedef struct packed {
        t_frame_status      status;
        logic [IDX_W-1:0]   index;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_sensor_result;

    typedef logic [BYTE_W-1:0] t_byte_q[$];

    typedef enum int {
        FR_GOOD,
        FR_BAD_SUM,
        FR_BAD_LEN,
        FR_OVERFLOW,
        FR_NOISE
    } t_frame_kind;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    sfd_in_if  in_bus ();
    sfd_out_if out_bus ();

    sensor_frame_deframer_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_bus.sink),
        .o_out      (out_bus.source)
    );

    logic [BYTE_W-1:0] frame_bytes [MAX_FRAME_BYTES];
    int unsigned       frame_len      = 0;
    bit                dropping       = 1'b0;
    logic [CFG_W-1:0]  sensor_count   = SENSOR_COUNT_RESET;
    t_sensor_result    pending_results[$];
    int unsigned       errors         = 0;
    int unsigned       bytes_sent     = 0;
    int unsigned       send_idle_pct  = 31;
    int unsigned       recv_idle_pct  = 53;
    int unsigned       recv_hold      = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("tb_sensor_frame_deframer_top: FAIL");
        $finish;
    end

    initial begin
        out_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (recv_hold > 0) begin
                out_bus.ready <= 1'b0;
                recv_hold--;
            end else begin
                out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            check_result();
        end
    end

    task automatic check_result();
        t_sensor_result want;
        t_sensor_result got;
        got = {out_bus.frame_status, out_bus.sensor_index, out_bus.sensor_value,
               out_bus.last};
        if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result status=%0d index=%0d value=%0h last=%0d",
                     $time, got.status, got.index, got.value, got.last);
        end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: mismatch expected status=%0d index=%0d value=%0h last=%0d",
                         $time, want.status, want.index, want.value, want.last);
                $display("%0t:          actual   status=%0d index=%0d value=%0h last=%0d",
                         $time, got.status, got.index, got.value, got.last);
            end
        end
    endtask

    task automatic push_result(input t_frame_status status, input logic [IDX_W-1:0] index,
                               input logic [VALUE_W-1:0] value, input logic last);
        pending_results.push_back('{status, index, value, last});
    endtask

    task automatic predict_byte(input logic [BYTE_W-1:0] b);
        int unsigned       n;
        int unsigned       nbytes;
        logic [BYTE_W-1:0] sum;
        if (dropping) begin
            if (b == NEWLINE) begin
                dropping  = 1'b0;
                frame_len = 0;
            end
        end else if (b == NEWLINE) begin
            n         = sensor_count;
            nbytes    = frame_len;
            frame_len = 0;
            if (n == 0 || n > MAX_SENSORS || nbytes != 2 * n + 1
                    || nbytes > MAX_FRAME_BYTES) begin
                push_result(ST_LEN, '0, '0, 1'b1);
            end else begin
                sum = '0;
                for (int i = 0; i < 2 * n; i++) sum ^= frame_bytes[i];
                if (sum != frame_bytes[2 * n]) begin
                    push_result(ST_CKSUM, '0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++) begin
                        push_result(ST_OK, IDX_W'(i),
                                    {frame_bytes[2 * i][FIELD_W-1:0],
                                     frame_bytes[2 * i + 1][FIELD_W-1:0]},
                                    (i == n - 1));
                    end
                end
            end
        end else if (frame_len >= MAX_FRAME_BYTES) begin
            frame_len = 0;
            dropping  = 1'b1;
            push_result(ST_OVF, '0, '0, 1'b1);
        end else begin
            frame_bytes[frame_len] = b - CHAR_OFFSET;
            frame_len++;
        end
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid   <= 1'b1;
        in_bus.rx_byte <= b;
        do @(posedge i_clk); while (!in_bus.ready);
        predict_byte(b);
        bytes_sent++;
    endtask

    task automatic wait_idle();
        in_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_sensor_count(input logic [CFG_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        sensor_count = v;
    endtask

    function automatic logic [BYTE_W-1:0] rand_data_byte();
        logic [BYTE_W-1:0] r;
        do r = BYTE_W'($urandom_range(255, 0)); while (r == NEWLINE);
        return r;
    endfunction

    function automatic t_byte_q random_payload(input int unsigned n);
        t_byte_q           data;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] check;
        do begin
            data.delete();
            sum = '0;
            for (int i = 0; i < 2 * n; i++) begin
                data.push_back(rand_data_byte());
                sum ^= data[i] - CHAR_OFFSET;
            end
            check = sum + CHAR_OFFSET;
        end while (check == NEWLINE);
        return data;
    endfunction

    task automatic send_frame(input t_byte_q data, input bit bad_sum);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] check;
        logic [BYTE_W-1:0] flip;
        sum = '0;
        foreach (data[i]) sum ^= data[i] - CHAR_OFFSET;
        check = sum + CHAR_OFFSET;
        if (bad_sum) begin
            do flip = BYTE_W'($urandom_range(255, 1)); while ((check ^ flip) == NEWLINE);
            check ^= flip;
        end
        foreach (data[i]) send_byte(data[i]);
        send_byte(check);
        send_byte(NEWLINE);
    endtask

    task automatic send_kind(input t_frame_kind kind);
        int unsigned n;
        int unsigned len;
        n = sensor_count;
        if (n == 0 || n > MAX_SENSORS) n = $urandom_range(3, 1);
        case (kind)
            FR_GOOD: begin
                send_frame(random_payload(n), 1'b0);
            end
            FR_BAD_SUM: begin
                send_frame(random_payload(n), 1'b1);
            end
            FR_BAD_LEN: begin
                do len = $urandom_range(MAX_FRAME_BYTES, 0); while (len == 2 * n + 1);
                repeat (len) send_byte(rand_data_byte());
                send_byte(NEWLINE);
            end
            FR_OVERFLOW: begin
                repeat (MAX_FRAME_BYTES + $urandom_range(6, 1)) send_byte(rand_data_byte());
                send_byte(NEWLINE);
            end
            default: begin
                repeat ($urandom_range(6, 1)) send_byte(BYTE_W'($urandom_range(255, 0)));
                send_byte(NEWLINE);
            end
        endcase
    endtask

    task automatic test_single_sensor_frames();
        send_frame({8'h20, 8'h20}, 1'b0);
        send_frame({8'h1F, 8'h1F}, 1'b0);
        send_frame({8'h00, 8'hFF}, 1'b0);
        send_frame({8'hE0, 8'h5F}, 1'b0);
        send_frame({8'h41, 8'h7E}, 1'b1);
        send_byte(NEWLINE);
        send_byte(8'h33);
        send_byte(NEWLINE);
        wait_idle();
    endtask

    task automatic test_bad_sensor_count();
        write_sensor_count(4'd0);
        send_frame({8'h21, 8'h22}, 1'b0);
        send_byte(NEWLINE);
        wait_idle();
        write_sensor_count(4'd15);
        send_byte(NEWLINE);
        send_frame(random_payload(2), 1'b0);
        wait_idle();
    endtask

    task automatic test_full_frame();
        t_byte_q data;
        write_sensor_count(CFG_W'(MAX_SENSORS));
        repeat (2 * MAX_SENSORS) data.push_back(8'h5F);
        send_frame(data, 1'b0);
        send_frame(random_payload(MAX_SENSORS), 1'b0);
        send_frame(random_payload(MAX_SENSORS), 1'b1);
        wait_idle();
    endtask

    task automatic test_overflow_discard();
        write_sensor_count(4'd2);
        repeat (MAX_FRAME_BYTES) send_byte(rand_data_byte());
        send_byte(NEWLINE);
        repeat (MAX_FRAME_BYTES + 1) send_byte(rand_data_byte());
        repeat (3) send_byte(rand_data_byte());
        send_byte(NEWLINE);
        send_frame(random_payload(2), 1'b0);
        send_byte(NEWLINE);
        wait_idle();
    endtask

    task automatic test_backpressure();
        write_sensor_count(4'd3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold     = 300;
        repeat (6) send_frame(random_payload(3), 1'b0);
        wait_idle();
    endtask

    task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                       input int unsigned budget);
        int unsigned start;
        int unsigned frames;
        int unsigned r;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start         = bytes_sent;
        frames        = 0;
        while (bytes_sent - start < budget) begin
            if (frames % 6 == 0) begin
                wait_idle();
                r = $urandom_range(99);
                if (r < 6)       write_sensor_count($urandom_range(1, 0) ? 4'd15 : 4'd0);
                else if (r < 15) write_sensor_count(CFG_W'(MAX_SENSORS));
                else if (r < 75) write_sensor_count(CFG_W'($urandom_range(4, 1)));
                else             write_sensor_count(CFG_W'($urandom_range(MAX_SENSORS - 1, 5)));
            end
            frames++;
            r = $urandom_range(99);
            if (r < 68)      send_kind(FR_GOOD);
            else if (r < 78) send_kind(FR_BAD_SUM);
            else if (r < 87) send_kind(FR_BAD_LEN);
            else if (r < 93) send_kind(FR_OVERFLOW);
            else             send_kind(FR_NOISE);
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        in_bus.valid   = 1'b0;
        in_bus.rx_byte = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_sensor_frames();
        test_bad_sensor_count();
        test_full_frame();
        test_overflow_discard();
        test_backpressure();
        test_random_traffic(31, 53, 60);
        test_random_traffic(53, 31, 60);
        test_random_traffic(0, 0, 60);

        repeat (40) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("tb_sensor_frame_deframer_top: PASS");
        end else begin
            $display("tb_sensor_frame_deframer_top: FAIL");
        end
        $finish;
    end

endmodule
